>>> src/slcd_pkg.sv
// Shared types, reset values and the CRC-8 byte update for the sync/length/CRC-8 deframer.
package slcd_pkg;

    // Widths of the beat fields and configuration port.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_W    = 16;

    // Register values after reset.
    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h55;
    localparam logic [LEN_W-1:0]  MAXLEN_RESET = 16'd1024;
    localparam logic [BYTE_W-1:0] POLY_RESET = 8'h07;
    localparam logic [BYTE_W-1:0] INIT_RESET = 8'h00;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_BYTE  = 8'd0,
        REG_MAX_LENGTH = 8'd1,
        REG_CRC_POLY   = 8'd2,
        REG_CRC_INIT   = 8'd3
    } cfg_reg_t;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_DATA   = 3'd3,
        PH_CHECK  = 3'd4
    } phase_t;

    // Event reported with each result beat.
    typedef enum logic [KIND_W-1:0] {
        EV_NONE    = 3'd0,
        EV_PAYLOAD = 3'd1,
        EV_ACCEPT  = 3'd2,
        EV_BADCRC  = 3'd3,
        EV_BADLEN  = 3'd4
    } event_t;

    // One byte of an MSB-first CRC-8, no reflection, no final xor.
    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data,
        input logic [BYTE_W-1:0] poly
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[BYTE_W-1])
                c = {c[BYTE_W-2:0], 1'b0} ^ poly;
            else
                c = {c[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> src/sync_length_crc8_deframer.sv
// Top level of the deframer: input register, frame parser and result register.
//
// Usage: received bytes enter on the input channel (in_valid, in_stall,
// rx_byte), one byte per beat. Every input beat produces exactly one result
// beat on the output channel (out_valid, out_stall, event_kind, payload_byte,
// frame_length, computed_crc). A frame is the sync byte, a big-endian 16-bit
// length, the payload and one CRC-8 byte. Payload bytes are passed through as
// they arrive, so the receiver drops a frame whose closing event is a CRC
// mismatch. A length above max_length is reported and the next two bytes are
// read as a new length.
// An accepted input beat waits in the input register while the parser works on
// it, and its result beat is then held in the result register. Throughput is
// one beat per cycle while the receiver does not stall; the parser step (phase update,
// length compare, one CRC-8 byte update) sits between those two registers.
// While the receiver stalls a pending result, the pipeline holds and in_stall
// rises once the input register is also full.
// Reset empties both registers, returns the parser to sync hunting and loads
// the configuration registers with their default values. Configuration is
// written through cfg_we, cfg_index and cfg_data; unknown indexes are ignored.
module sync_length_crc8_deframer
    import slcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // Input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    rx_byte,
    // Output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [KIND_W-1:0]    event_kind,
    output logic [BYTE_W-1:0]    payload_byte,
    output logic [LEN_W-1:0]     frame_length,
    output logic [BYTE_W-1:0]    computed_crc
);

    // Configuration registers
    logic [BYTE_W-1:0] sync_byte_reg;
    logic [LEN_W-1:0]  max_length_reg;
    logic [BYTE_W-1:0] crc_poly_reg;
    logic [BYTE_W-1:0] crc_init_reg;

    // Pipeline registers
    logic              in_vld_reg;
    logic [BYTE_W-1:0] rx_reg;
    logic              out_valid_reg;
    event_t            kind_reg;
    logic [BYTE_W-1:0] pay_reg;
    logic [LEN_W-1:0]  flen_reg;
    logic [BYTE_W-1:0] ccrc_reg;

    // Parser state
    phase_t            phase_reg;
    phase_t            phase_next;
    logic [LEN_W-1:0]  length_reg;
    logic [LEN_W-1:0]  length_next;
    logic [LEN_W-1:0]  bytes_left_reg;
    logic [LEN_W-1:0]  bytes_left_next;
    logic [BYTE_W-1:0] crc_acc_reg;
    logic [BYTE_W-1:0] crc_acc_next;

    // Result of the current parser step
    event_t            kind_next;
    logic [BYTE_W-1:0] pay_next;
    logic [LEN_W-1:0]  flen_next;
    logic [BYTE_W-1:0] ccrc_next;
    logic [LEN_W-1:0]  len_full;
    logic [LEN_W-1:0]  left_dec;

    logic advance;
    logic step;
    logic in_accept;

    // The result register frees up when it is empty or being taken.
    assign advance   = !out_valid_reg || !out_stall;
    assign step      = in_vld_reg && advance;
    assign in_stall  = in_vld_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg  <= SYNC_RESET;
            max_length_reg <= MAXLEN_RESET;
            crc_poly_reg   <= POLY_RESET;
            crc_init_reg   <= INIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SYNC_BYTE:  sync_byte_reg  <= cfg_data[BYTE_W-1:0];
                REG_MAX_LENGTH: max_length_reg <= cfg_data[LEN_W-1:0];
                REG_CRC_POLY:   crc_poly_reg   <= cfg_data[BYTE_W-1:0];
                REG_CRC_INIT:   crc_init_reg   <= cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (advance || in_accept)
            in_vld_reg <= in_accept;
    end

    // Input byte; it only loads when a new beat is accepted.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            rx_reg <= rx_byte;
    end

    // Parser step over the byte held in the input register.
    always_comb
    begin
        phase_next      = phase_reg;
        length_next     = length_reg;
        bytes_left_next = bytes_left_reg;
        crc_acc_next    = crc_acc_reg;
        kind_next       = EV_NONE;
        pay_next        = '0;
        flen_next       = '0;
        ccrc_next       = '0;
        len_full        = {length_reg[LEN_W-1:BYTE_W], rx_reg};
        left_dec        = bytes_left_reg - LEN_W'(1);

        case (phase_reg)
            PH_LEN_HI:
            begin
                length_next = {rx_reg, BYTE_W'(0)};
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                length_next = len_full;
                if (len_full <= max_length_reg)
                begin
                    crc_acc_next    = crc_init_reg;
                    bytes_left_next = len_full;
                    phase_next      = (len_full == '0) ? PH_CHECK : PH_DATA;
                end
                else
                begin
                    kind_next  = EV_BADLEN;
                    flen_next  = len_full;
                    phase_next = PH_LEN_HI;
                end
            end
            PH_DATA:
            begin
                kind_next       = EV_PAYLOAD;
                pay_next        = rx_reg;
                crc_acc_next    = crc8_byte(crc_acc_reg, rx_reg, crc_poly_reg);
                bytes_left_next = left_dec;
                if (left_dec == '0)
                    phase_next = PH_CHECK;
            end
            PH_CHECK:
            begin
                kind_next  = (rx_reg == crc_acc_reg) ? EV_ACCEPT : EV_BADCRC;
                flen_next  = length_reg;
                ccrc_next  = crc_acc_reg;
                phase_next = PH_HUNT;
            end
            default:
            begin
                // Hunting, and any phase code that means nothing.
                phase_next = (rx_reg == sync_byte_reg) ? PH_LEN_HI : PH_HUNT;
            end
        endcase
    end

    // Parser state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            length_reg     <= '0;
            bytes_left_reg <= '0;
            crc_acc_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg      <= phase_next;
                length_reg     <= length_next;
                bytes_left_reg <= bytes_left_next;
                crc_acc_reg    <= crc_acc_next;
            end
            if (advance)
                out_valid_reg <= in_vld_reg;
        end
    end

    // Result payload; it only loads on a parser step.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            kind_reg <= kind_next;
            pay_reg  <= pay_next;
            flen_reg <= flen_next;
            ccrc_reg <= ccrc_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign payload_byte = pay_reg;
    assign frame_length = flen_reg;
    assign computed_crc = ccrc_reg;

    // The payload phase is only entered with bytes still to come.
    a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> bytes_left_reg != '0)
        else $error("payload phase with no bytes left");

    // A step in the payload phase delivers a payload event next cycle.
    a_data_gives_payload: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_DATA |=> out_valid_reg && kind_reg == EV_PAYLOAD)
        else $error("payload step did not give a payload event");

    // Only payload events carry a byte.
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != EV_PAYLOAD |-> pay_reg == '0)
        else $error("payload byte set on a non-payload event");

    // A rejected length sends the parser back to reading a length.
    a_badlen_rereads: assert property (@(posedge clk) disable iff (!rst_n)
        step && kind_next == EV_BADLEN |=> phase_reg == PH_LEN_HI)
        else $error("rejected length did not restart length read");

endmodule
